[rtl/bwrd_pkg.sv]
`timescale 1ns / 1ps
// bwrd_pkg: shared constants, status codes and control struct of the repeat detector
// no dependencies

package bwrd_pkg;

	localparam int unsigned MAX_WINDOW_DEF   = 20;
	localparam int unsigned LEN_W            = 5;
	localparam int unsigned LEN_CMP_W        = 6;
	localparam int unsigned WINDOW_LEN_MIN   = 4;
	localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 5'd16;
	localparam int unsigned POS_W            = 32;
	localparam int unsigned STATUS_W         = 2;

	localparam logic [STATUS_W-1:0] ST_FILLING  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_REP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REPEAT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ENDED    = 2'd3;

	// seen map row geometry: log2 of bits per row
	function automatic int unsigned row_log(input int unsigned max_w);
		return (max_w >= 10) ? 5 : 2;
	endfunction

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear_start;
	} map_ctl_t;

endpackage

[rtl/bwrd_ifs.sv]
`timescale 1ns / 1ps
// bwrd_in_if / bwrd_out_if: valid-ready channels of the repeat detector
// depends on bwrd_pkg

interface bwrd_in_if import bwrd_pkg::*; ;
	logic valid;
	logic ready;
	logic data_bit;
	logic first_bit;
	logic last_bit;

	modport source (output valid, data_bit, first_bit, last_bit, input ready);
	modport sink (input valid, data_bit, first_bit, last_bit, output ready);
endinterface

interface bwrd_out_if import bwrd_pkg::*; #(
	parameter int unsigned VALUE_W = MAX_WINDOW_DEF
);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [VALUE_W-1:0]  window_value;

	modport source (output valid, status, position, window_value, input ready);
	modport sink (input valid, status, position, window_value, output ready);
endinterface

[rtl/bit_window_repeat_detector.sv]
`timescale 1ns / 1ps
// a request passes stage 1 (map row read) and is then loaded into the output register
// throughput: one bit per cycle unless stalled; a forwarded row read-modify-write per bit
// a first_bit on a used pass waits for stage 1 to drain, then a clear of
// 2^(MAX_WINDOW-5) rows (32768 rows at the default, MAX_WINDOW of 10 or more)
// reset: control clears at once, the same row clear then runs before the first request
// depends on bwrd_pkg, bwrd_ifs, bwrd_seen_map

module bit_window_repeat_detector import bwrd_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	bwrd_in_if.sink          in_req,
	bwrd_out_if.source       out_res
);

	localparam int unsigned RowLog  = row_log(MAX_WINDOW);
	localparam int unsigned RowBits = 1 << RowLog;

	// configuration
	logic [LEN_W-1:0]     len_q;
	logic [LEN_CMP_W-1:0] len_raw;
	logic [LEN_CMP_W-1:0] len_eff;
	logic [MAX_WINDOW-1:0] len_mask;

	// pass state
	logic [MAX_WINDOW-1:0] window_q;
	logic [POS_W-1:0]      count_q;
	logic                  found_q;
	logic [POS_W-1:0]      found_pos_q;
	logic [MAX_WINDOW-1:0] found_val_q;
	logic                  fresh_q;

	// stage 1: request whose map row is being read
	logic                  s1_valid_q;
	logic [MAX_WINDOW-1:0] win_s1;
	logic [POS_W-1:0]      idx_s1;
	logic                  elig_s1;
	logic                  last_s1;

	// output register
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [POS_W-1:0]      position_q;
	logic [MAX_WINDOW-1:0] value_q;

	logic                  accept;
	logic                  s1_adv;
	logic                  clear_req;
	logic                  map_busy;
	logic [MAX_WINDOW-1:0] win_next;
	logic                  elig_next;
	logic [RowBits-1:0]    map_rd_data;
	logic [RowBits-1:0]    row_data;
	logic [RowBits-1:0]    row_set;
	logic                  hit;
	logic                  new_repeat;
	logic [STATUS_W-1:0]   status_d;
	logic [POS_W-1:0]      position_d;
	logic [MAX_WINDOW-1:0] value_d;
	map_ctl_t              map_ctl;

	// window length clamped to 4..MAX_WINDOW
	always_comb begin
		len_raw = {{(LEN_CMP_W-LEN_W){1'b0}}, len_q};
		len_eff = len_raw;
		if (len_raw < LEN_CMP_W'(WINDOW_LEN_MIN)) begin
			len_eff = LEN_CMP_W'(WINDOW_LEN_MIN);
		end
		if (len_raw > LEN_CMP_W'(MAX_WINDOW)) begin
			len_eff = LEN_CMP_W'(MAX_WINDOW);
		end
		for (int i = 0; i < MAX_WINDOW; i++) begin
			len_mask[i] = (LEN_CMP_W'(i) < len_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= WINDOW_LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// handshake: no request during a clear; a first_bit waits for a clean map
	assign s1_adv = s1_valid_q && (!out_valid_q || out_res.ready);
	assign in_req.ready = !map_busy && (!s1_valid_q || s1_adv)
		&& (!in_req.first_bit || fresh_q);
	assign accept = in_req.valid && in_req.ready;

	// start the clear once stage 1 has drained and nothing else is pending
	assign clear_req = in_req.valid && in_req.first_bit && !fresh_q
		&& !map_busy && !s1_valid_q;

	// newest bit enters at the bottom of the window
	assign win_next  = {window_q[MAX_WINDOW-2:0], in_req.data_bit} & len_mask;
	assign elig_next = count_q >= (POS_W'(len_eff) - POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			found_pos_q <= '0;
			found_val_q <= '0;
			fresh_q     <= 1'b1;
		end else if (clear_req) begin
			window_q    <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			found_pos_q <= '0;
			found_val_q <= '0;
			fresh_q     <= 1'b1;
		end else begin
			if (accept) begin
				window_q <= win_next;
				// index saturates at the top of the counter
				if (count_q != {POS_W{1'b1}}) begin
					count_q <= count_q + POS_W'(1);
				end
				fresh_q <= 1'b0;
			end
			if (s1_adv && new_repeat) begin
				found_q     <= 1'b1;
				found_pos_q <= idx_s1;
				found_val_q <= win_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1  <= win_next;
			idx_s1  <= count_q;
			elig_s1 <= elig_next;
			last_s1 <= in_req.last_bit;
		end
	end

	// lookup and mark; the map forwards a same-row write to the read behind it
	assign row_data   = map_rd_data;
	assign hit        = row_data[win_s1[RowLog-1:0]];
	assign row_set    = row_data | (RowBits'(1) << win_s1[RowLog-1:0]);
	assign new_repeat = !found_q && elig_s1 && hit;

	always_comb begin
		map_ctl.rd_en       = accept;
		map_ctl.wr_en       = s1_adv && !found_q && elig_s1 && !hit;
		map_ctl.clear_start = clear_req;
	end

	bwrd_seen_map #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_seen_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (map_ctl),
		.rd_row  (win_next[MAX_WINDOW-1:RowLog]),
		.wr_row  (win_s1[MAX_WINDOW-1:RowLog]),
		.wr_data (row_set),
		.rd_data (map_rd_data),
		.busy    (map_busy)
	);

	// result of the bit in stage 1
	always_comb begin
		status_d   = ST_FILLING;
		position_d = '0;
		value_d    = '0;
		if (found_q) begin
			// bits after a repeat change nothing
			status_d   = ST_REPEAT;
			position_d = found_pos_q;
			value_d    = found_val_q;
		end else if (new_repeat) begin
			status_d   = ST_REPEAT;
			position_d = idx_s1;
			value_d    = win_s1;
		end else begin
			status_d = elig_s1 ? ST_NO_REP : ST_FILLING;
			if (last_s1) begin
				status_d = ST_ENDED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q   <= status_d;
			position_q <= position_d;
			value_q    <= value_d;
		end
	end

	assign out_res.valid        = out_valid_q;
	assign out_res.status       = status_q;
	assign out_res.position     = position_q;
	assign out_res.window_value = value_q;

	// a latched repeat holds until a new pass clears it
	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !clear_req |=> found_q)
		else $error("repeat flag dropped without a new pass");

	// the clear only starts with stage 1 empty
	a_clear_drained: assert property (@(posedge clk) disable iff (!arst_n)
		clear_req |-> !s1_valid_q && !map_busy)
		else $error("map clear started with a bit in flight");

	// no request taken while the map is being cleared
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !accept && !map_ctl.wr_en)
		else $error("map access during clear");

	// position and value are zero unless a repeat is reported
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_REPEAT) |-> (position_q == '0) && (value_q == '0))
		else $error("payload set without a repeat");

endmodule

[rtl/bwrd_seen_map.sv]
`timescale 1ns / 1ps
// bwrd_seen_map: bitmap of seen window values, rows of bits in one synchronous ram
// write-first read, plus a row-by-row clear sweep; depends on bwrd_pkg

module bwrd_seen_map import bwrd_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  map_ctl_t                             ctl,
	input  logic [MAX_WINDOW-row_log(MAX_WINDOW)-1:0] rd_row,
	input  logic [MAX_WINDOW-row_log(MAX_WINDOW)-1:0] wr_row,
	input  logic [(1 << row_log(MAX_WINDOW))-1:0]     wr_data,
	output logic [(1 << row_log(MAX_WINDOW))-1:0]     rd_data,
	output logic                                 busy
);

	localparam int unsigned RowLog  = row_log(MAX_WINDOW);
	localparam int unsigned RowBits = 1 << RowLog;
	localparam int unsigned RowsLog = MAX_WINDOW - RowLog;
	localparam int unsigned Rows    = 1 << RowsLog;

	logic [RowBits-1:0] mem [Rows];
	logic [RowsLog-1:0] clr_addr_q;
	logic               busy_q;
	logic [RowBits-1:0] rd_data_q;

	// sweep runs after reset and on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (ctl.clear_start) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + RowsLog'(1);
			if (clr_addr_q == {RowsLog{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (ctl.rd_en) begin
			// same-row write in this cycle wins
			if (ctl.wr_en && !busy_q && (wr_row == rd_row)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_row];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

[test/tb_bit_window_repeat_detector.sv]
`timescale 1ns / 1ps
// tb_bit_window_repeat_detector: self-checking bench for the bit-window repeat detector,
// with a scoreboard class that predicts one result per request and checks results in order
// depends on bwrd_pkg, bwrd_ifs and the detector rtl

module tb_bit_window_repeat_detector import bwrd_pkg::*; ;

	localparam int unsigned VW = MAX_WINDOW_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [VW-1:0]       window_value;
	} detect_result_t;

	// predicts the detector and holds the results still owed by it
	class repeat_scoreboard;
		logic [LEN_W-1:0] window_length = WINDOW_LEN_RESET;
		logic [VW-1:0]    window_bits;
		logic [POS_W-1:0] bit_count;
		bit               found_flag;
		logic [POS_W-1:0] found_position;
		logic [VW-1:0]    found_value;
		bit               seen_map [int unsigned];
		detect_result_t   expected_results [$];
		int unsigned      errors;
		int unsigned      checked;

		function void clear_pass();
			seen_map.delete();
			window_bits    = '0;
			bit_count      = '0;
			found_flag     = 1'b0;
			found_position = '0;
			found_value    = '0;
		endfunction

		function new();
			clear_pass();
			errors  = 0;
			checked = 0;
		endfunction

		// returns 1 when the request still had an effect (no repeat latched before it)
		function bit note_request(bit d, bit f, bit l);
			detect_result_t r;
			int unsigned    len;
			logic [31:0]    mask;
			logic [31:0]    wide;
			logic [31:0]    idx;
			bit             live;
			if (f)
				clear_pass();
			r    = '0;
			live = !found_flag;
			if (found_flag) begin
				r.status = ST_REPEAT;
			end else begin
				len = window_length;
				if (len < WINDOW_LEN_MIN)
					len = WINDOW_LEN_MIN;
				if (len > MAX_WINDOW_DEF)
					len = MAX_WINDOW_DEF;
				mask        = (32'd1 << len) - 32'd1;
				idx         = bit_count;
				wide        = ((32'(window_bits) << 1) | 32'(d)) & mask;
				window_bits = wide[VW-1:0];
				if (bit_count != '1)
					bit_count = bit_count + 1;
				if (idx >= len - 1) begin
					if (seen_map.exists(int'(window_bits))) begin
						found_flag     = 1'b1;
						found_position = idx;
						found_value    = window_bits;
						r.status       = ST_REPEAT;
					end else begin
						seen_map[int'(window_bits)] = 1'b1;
						r.status = ST_NO_REP;
					end
				end else begin
					r.status = ST_FILLING;
				end
				if (!found_flag && l)
					r.status = ST_ENDED;
			end
			if (r.status == ST_REPEAT) begin
				r.position     = found_position;
				r.window_value = found_value;
			end
			expected_results.push_back(r);
			return live;
		endfunction

		function void check_result(detect_result_t got);
			detect_result_t exp;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d position %0d value %h",
						got.status, got.position, got.window_value);
				return;
			end
			exp = expected_results.pop_front();
			if (got.status !== exp.status || got.position !== exp.position ||
					got.window_value !== exp.window_value) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected %0d/%0d/%h, got %0d/%0d/%h",
						checked, exp.status, exp.position, exp.window_value,
						got.status, got.position, got.window_value);
			end
			checked++;
		endfunction
	endclass

	localparam int unsigned ITEMS       = 1200;
	localparam int unsigned HOLD_CYCLES = 400;
	// reset clear plus one row clear per pass start, stalls and gaps several times over
	localparam int unsigned CYCLE_LIMIT = 6_000_000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	bwrd_in_if                    in_ch ();
	bwrd_out_if #(.VALUE_W(VW))   out_ch ();

	bit_window_repeat_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_req    (in_ch),
		.out_res   (out_ch)
	);

	repeat_scoreboard sb = new();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holds_asked    = 0;
	int unsigned holds_served   = 0;
	int unsigned hold_left      = 0;
	int unsigned live_requests  = 0;
	int unsigned cycles         = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_bit_window_repeat_detector NOT OK");
			$finish;
		end
	end

	// monitor: note each accepted request, then check each accepted result
	// (a result never belongs to a request taken at the same edge, it passes stage 1 and the output register first)
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				if (sb.note_request(in_ch.data_bit, in_ch.first_bit, in_ch.last_bit))
					live_requests <= live_requests + 1;
			end
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.status, out_ch.position, out_ch.window_value});
		end
	end

	// result side: random stalls, and on demand one long hold-off so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one request and hold it until taken; valid stays up for a back-to-back request
	task automatic send_bit(input bit d, input bit f, input bit l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_bit  <= d;
		in_ch.first_bit <= f;
		in_ch.last_bit  <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// stop offering, wait for every owed result, then let the pipeline settle
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.window_length = v;
	endtask

	task automatic set_idling(input int unsigned m);
		case (m % 4)
			0: begin
				send_idle_pct = 0;  recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 65; recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;  recv_stall_pct = 65;
			end
			default: begin
				send_idle_pct = 34; recv_stall_pct = 34;
			end
		endcase
	endtask

	// one stretch of bits: a new pass, or the current one carried on after a length change
	task automatic send_stretch(input bit new_pass);
		int unsigned n;
		int unsigned mode;
		int unsigned period;
		int unsigned extra;
		logic [31:0] pattern;
		bit          d;
		bit          l;
		n       = $urandom_range(30, 250);
		mode    = $urandom_range(99);
		period  = $urandom_range(1, 32);
		pattern = $urandom;
		extra   = 0;
		for (int unsigned k = 0; k < n; k++) begin
			if (mode < 40)
				d = pattern[k % period];      // periodic content repeats quickly
			else if (mode < 80)
				d = 1'($urandom_range(1));
			else if (mode < 90)
				d = 1'b1;
			else
				d = 1'b0;
			// mostly a clean end of pass, now and then a stray last flag mid-stream
			l = (k == n - 1) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 3);
			send_bit(d, new_pass && (k == 0), l);
			// bits after a repeat are ignored, so only a few are sent
			if (sb.found_flag) begin
				extra++;
				if (extra > 3)
					break;
			end
		end
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] len_extremes [6];
		logic [LEN_W-1:0] len;
		int unsigned      phase;
		bit               carry_on;
		len_extremes = '{5'd0, 5'd3, 5'd4, 5'd20, 5'd21, 5'd31};

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.data_bit  = 1'b0;
		in_ch.first_bit = 1'b0;
		in_ch.last_bit  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, shortest window
		write_length(5'd4);
		// alternating bits: 1010 comes back at bit five, later bits and last flag ignored
		send_bit(1'b1, 1'b1, 1'b0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b1);
		// first and last together: a single-bit pass
		send_bit(1'b1, 1'b1, 1'b1);
		// last while the window is filling, then the same pass goes on
		send_bit(1'b0, 1'b1, 1'b0);
		send_bit(1'b1, 1'b0, 1'b1);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		// length below the minimum, changed mid-pass
		wait_drain();
		write_length(5'd0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b1 & 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		// length above the maximum, mid-pass again, old marks kept
		wait_drain();
		write_length(5'd31);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b1);

		// back-pressure: results held off while requests keep coming
		wait_drain();
		write_length(5'd20);
		set_idling(0);
		for (int unsigned k = 0; k < 150; k++) begin
			send_bit(1'($urandom_range(1)), k == 0, k == 149);
			// hold off once the map clear of the new pass is over
			if (k == 0)
				holds_asked = holds_asked + 1;
		end
		// sender pauses until every owed result is back
		wait_drain();

		// random part: passes and mid-pass length changes, idling by phase
		phase = 0;
		while (live_requests < ITEMS && phase < 40) begin
			phase++;
			set_idling(phase);
			case ($urandom_range(3))
				0: len = LEN_W'($urandom_range(31));
				1: len = LEN_W'($urandom_range(4, 8));
				2: len = LEN_W'($urandom_range(9, 20));
				default: len = len_extremes[$urandom_range(5)];
			endcase
			carry_on = !sb.found_flag && ($urandom_range(99) < 35);
			write_length(len);
			send_stretch(!carry_on);
			wait_drain();
		end

		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("tb_bit_window_repeat_detector OK");
		end else begin
			if (sb.expected_results.size() != 0)
				$display("%0d results never arrived", sb.expected_results.size());
			$display("tb_bit_window_repeat_detector NOT OK");
		end
		$finish;
	end

endmodule
